// ===== rtl/pidfd_pkg.sv =====
// types and constants shared by the pid controller modules
`timescale 1ns / 1ps
`default_nettype none
package pidfd_pkg;

  localparam int DataW  = 32;
  localparam int StepW  = 24;
  localparam int MulW   = 33;
  localparam int ProdW  = 2 * MulW;
  localparam int NumW   = 57;
  localparam int DenW   = 25;
  localparam int AccW   = 50;
  localparam int CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] REG_VARIANT  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_GAIN_P   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_GAIN_I   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_GAIN_D   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_INT_LIM  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_TAU      = 3'd5;

  localparam logic [1:0] VAR_PID_FILT = 2'd0;
  localparam logic [1:0] VAR_PID_RAW  = 2'd1;
  localparam logic [1:0] VAR_PD_FILT  = 2'd2;

  localparam logic [StepW-1:0] TAU_RESET = 24'd267021;

  typedef struct packed {
    logic signed [DataW-1:0] error_in;
    logic [StepW-1:0]        time_step;
    logic                    clear_state;
  } in_word_t;

  typedef struct packed {
    logic signed [DataW-1:0] drive_out;
    logic                    saturated;
  } out_word_t;

  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [NumW-1:0] quot;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_P,
    ST_PA,
    ST_IE,
    ST_IC,
    ST_IM,
    ST_IA,
    ST_DSEL,
    ST_DD,
    ST_DA,
    ST_FM,
    ST_FA,
    ST_DM,
    ST_DMA,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/pid_with_filtered_derivative.sv =====
// pid controller top level: sequencer, state and configuration registers
`timescale 1ns / 1ps
`default_nettype none
// PID controller with optional low-pass filtered derivative in fixed point
// (Q16.16 values and gains, Q0.24 time step). One word is worked at a time on a
// single shared 33x33 multiplier and a single restoring divider that yields
// one quotient bit per cycle. A clear word goes straight to the output state;
// a normal word forms the proportional term, then the integral term when it is
// enabled, then the derivative product when the derivative is updated; a raw
// or primed update adds the difference division, and a primed filtered update
// also the filter coefficient division and the filter update. A result still
// waiting on out_ready holds the block in its output state until it is taken.
// in_ready is high only while idle.
module pid_with_filtered_derivative
  import pidfd_pkg::*;
(
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire  in_word_t           in_word,
  output logic                     out_valid,
  input  wire                      out_ready,
  output out_word_t                out_word,
  input  wire                      cfg_we,
  input  wire  logic [CfgIdxW-1:0] cfg_index,
  input  wire  logic [DataW-1:0]   cfg_wdata
);

  state_t state_r, state_nxt;

  logic [1:0]              variant_r;
  logic signed [DataW-1:0] gain_p_r, gain_i_r, gain_d_r;
  logic [DataW-2:0]        lim_r;
  logic [StepW-1:0]        tau_r;

  logic signed [DataW-1:0] integ_r, integ_nxt, dv_r, dv_nxt, prev_r, prev_nxt;
  logic signed [DataW-1:0] raw_r, raw_nxt;
  logic                    primed_r, primed_nxt;
  logic signed [DataW-1:0] err_r;
  logic [StepW-1:0]        dt_r;
  logic [DenW-1:0]         alpha_r, alpha_nxt;
  logic signed [AccW-1:0]  acc_r, acc_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_word_t               out_r, out_nxt;

  logic signed [MulW-1:0]  mul_a, mul_b;
  logic signed [ProdW-1:0] prod;
  div_req_t                dreq;
  div_rsp_t                drsp;

  logic                    do_i, do_d, accept;
  logic signed [MulW-1:0]  diff;
  logic [MulW-1:0]         diff_mag;
  logic signed [MulW:0]    itmp, lim_pos, lim_neg;
  logic signed [MulW:0]    ftmp;
  logic [NumW-1:0]         q;
  logic                    q_big;

  pidfd_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod)
  );

  pidfd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      variant_r <= VAR_PID_FILT;
      gain_p_r  <= '0;
      gain_i_r  <= '0;
      gain_d_r  <= '0;
      lim_r     <= '0;
      tau_r     <= TAU_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VARIANT: variant_r <= cfg_wdata[1:0];
        REG_GAIN_P:  gain_p_r  <= cfg_wdata;
        REG_GAIN_I:  gain_i_r  <= cfg_wdata;
        REG_GAIN_D:  gain_d_r  <= cfg_wdata;
        REG_INT_LIM: lim_r     <= cfg_wdata[DataW-2:0];
        REG_TAU:     tau_r     <= cfg_wdata[StepW-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign do_i     = (variant_r != VAR_PD_FILT) && (gain_i_r != '0) && (dt_r != '0);
  assign do_d     = (gain_d_r != '0) && (dt_r != '0);
  assign diff     = MulW'(err_r) - MulW'(prev_r);
  assign diff_mag = diff[MulW-1] ? MulW'(-diff) : diff;
  assign q        = drsp.quot;

  always_comb begin
    state_nxt     = state_r;
    integ_nxt     = integ_r;
    dv_nxt        = dv_r;
    prev_nxt      = prev_r;
    raw_nxt       = raw_r;
    primed_nxt    = primed_r;
    alpha_nxt     = alpha_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    mul_a         = MulW'(gain_p_r);
    mul_b         = MulW'(err_r);
    dreq.start    = 1'b0;
    dreq.num      = {diff_mag, {StepW{1'b0}}};
    dreq.den      = DenW'(dt_r);
    lim_pos       = (MulW+1)'({1'b0, lim_r});
    lim_neg       = -lim_pos;
    itmp          = (MulW+1)'(integ_r) + prod[57:24];
    ftmp          = (MulW+1)'(dv_r) + prod[57:24];
    q_big         = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_word.clear_state) begin
            integ_nxt  = '0;
            dv_nxt     = '0;
            prev_nxt   = '0;
            primed_nxt = 1'b0;
            acc_nxt    = '0;
            state_nxt  = ST_OUT;
          end else begin
            state_nxt = ST_P;
          end
        end
      end
      ST_P: state_nxt = ST_PA;
      ST_PA: begin
        acc_nxt   = prod[65:16];
        state_nxt = do_i ? ST_IE : ST_DSEL;
      end
      ST_IE: begin
        mul_a     = MulW'(err_r);
        mul_b     = MulW'({1'b0, dt_r});
        state_nxt = ST_IC;
      end
      ST_IC: begin
        if (itmp > lim_pos) begin
          integ_nxt = DataW'(lim_pos);
        end else if (itmp < lim_neg) begin
          integ_nxt = DataW'(lim_neg);
        end else begin
          integ_nxt = DataW'(itmp);
        end
        state_nxt = ST_IM;
      end
      ST_IM: begin
        mul_a     = MulW'(gain_i_r);
        mul_b     = MulW'(integ_r);
        state_nxt = ST_IA;
      end
      ST_IA: begin
        acc_nxt   = acc_r + prod[65:16];
        state_nxt = ST_DSEL;
      end
      ST_DSEL: begin
        if (!do_d) begin
          state_nxt = ST_OUT;
        end else if (variant_r == VAR_PID_RAW || primed_r) begin
          dreq.start = 1'b1;
          state_nxt  = ST_DD;
        end else begin
          dv_nxt    = '0;
          state_nxt = ST_DM;
        end
      end
      ST_DD: begin
        if (drsp.done) begin
          if (diff[MulW-1]) begin
            q_big   = (q > NumW'(33'h080000000));
            raw_nxt = q_big ? {1'b1, {(DataW-1){1'b0}}} : DataW'(-q);
          end else begin
            q_big   = (q > NumW'(33'h07fffffff));
            raw_nxt = q_big ? {1'b0, {(DataW-1){1'b1}}} : DataW'(q);
          end
          if (variant_r == VAR_PID_RAW) begin
            dv_nxt    = raw_nxt;
            state_nxt = ST_DM;
          end else begin
            dreq.start = 1'b1;
            dreq.num   = NumW'({dt_r, {StepW{1'b0}}});
            dreq.den   = DenW'(tau_r) + DenW'(dt_r);
            state_nxt  = ST_DA;
          end
        end
      end
      ST_DA: begin
        if (drsp.done) begin
          alpha_nxt = q[DenW-1:0];
          state_nxt = ST_FM;
        end
      end
      ST_FM: begin
        mul_a     = MulW'({1'b0, alpha_r});
        mul_b     = MulW'(raw_r) - MulW'(dv_r);
        state_nxt = ST_FA;
      end
      ST_FA: begin
        dv_nxt    = DataW'(ftmp);
        state_nxt = ST_DM;
      end
      ST_DM: begin
        mul_a      = MulW'(gain_d_r);
        mul_b      = MulW'(dv_r);
        prev_nxt   = err_r;
        primed_nxt = 1'b1;
        state_nxt  = ST_DMA;
      end
      ST_DMA: begin
        acc_nxt   = acc_r + prod[65:16];
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          if (acc_r > AccW'(33'sh07fffffff)) begin
            out_nxt.drive_out = {1'b0, {(DataW-1){1'b1}}};
            out_nxt.saturated = 1'b1;
          end else if (acc_r < -AccW'(33'sh080000000)) begin
            out_nxt.drive_out = {1'b1, {(DataW-1){1'b0}}};
            out_nxt.saturated = 1'b1;
          end else begin
            out_nxt.drive_out = acc_r[DataW-1:0];
            out_nxt.saturated = 1'b0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      integ_r     <= '0;
      dv_r        <= '0;
      prev_r      <= '0;
      primed_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      integ_r     <= integ_nxt;
      dv_r        <= dv_nxt;
      prev_r      <= prev_nxt;
      primed_r    <= primed_nxt;
    end
    raw_r   <= raw_nxt;
    alpha_r <= alpha_nxt;
    acc_r   <= acc_nxt;
    out_r   <= out_nxt;
    if (accept) begin
      err_r <= in_word.error_in;
      dt_r  <= in_word.time_step;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

`ifndef SYNTHESIS
  a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !drsp.busy)
    else $error("divider busy while idle");

  a_integ_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IC |=> (integ_r <= $signed({1'b0, lim_r}))
                         && (integ_r >= -$signed({1'b0, lim_r})))
    else $error("integrator outside limit");

  a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_word.clear_state |=> state_r == ST_OUT && integ_r == '0
                                      && !primed_r && acc_r == '0)
    else $error("clear did not reset state");
`endif

endmodule
`default_nettype wire

// ===== rtl/pidfd_mul.sv =====
// shared signed multiplier with registered product
`timescale 1ns / 1ps
`default_nettype none
module pidfd_mul
  import pidfd_pkg::*;
(
  input  wire                           clk,
  input  wire  logic signed [MulW-1:0]  mul_a,
  input  wire  logic signed [MulW-1:0]  mul_b,
  output logic signed [ProdW-1:0]       prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

endmodule
`default_nettype wire

// ===== rtl/pidfd_div.sv =====
// shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module pidfd_div
  import pidfd_pkg::*;
(
  input  wire             clk,
  input  wire             rst_n,
  input  wire  div_req_t  req,
  output div_rsp_t        rsp
);

  localparam int CntW = $clog2(NumW);

  logic [NumW-1:0] num_r, num_nxt;
  logic [DenW-1:0] rem_r, rem_nxt, den_r;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt, done_r, done_nxt;
  logic [DenW:0]   trial;
  logic            qbit;

  always_comb begin
    trial    = {rem_r, num_r[NumW-1]};
    qbit     = (trial >= {1'b0, den_r});
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      num_nxt  = req.num;
      rem_nxt  = '0;
      cnt_nxt  = CntW'(NumW - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[NumW-2:0], qbit};
      rem_nxt = qbit ? DenW'(trial - {1'b0, den_r}) : trial[DenW-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (req.start) begin
      den_r <= req.den;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = num_r;

endmodule
`default_nettype wire
